[src/terrain_border_selector_top_assert.svh]
// Assertion macros for the terrain border selector.
`ifndef TERRAIN_BORDER_SELECTOR_TOP_ASSERT_SVH
`define TERRAIN_BORDER_SELECTOR_TOP_ASSERT_SVH

// same-cycle implication, checked out of reset
`define TBS_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// next-cycle implication, checked out of reset
`define TBS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

[src/tbs_pkg.sv]
// Shared types and constants of the terrain border selector.
package tbs_pkg;

    localparam int TERRAIN_W = 5;
    localparam int BORDER_W  = 4;
    localparam int SHAPE_W   = 4;
    localparam int MASK_W    = 16;
    localparam int NUM_LANES = 8;

    localparam logic [TERRAIN_W-1:0] ENTRY_NONE = 5'h1F;

    typedef enum logic {
        OP_WRITE    = 1'b0,
        OP_CLASSIFY = 1'b1
    } op_t;

    typedef enum logic {
        REG_LOADED_MASK = 1'b0,
        REG_STYLE1_MASK = 1'b1
    } reg_idx_t;

    // lane order: top, bottom, left, right, top left, top right, bottom left, bottom right
    localparam int L_TOP = 0;
    localparam int L_BOT = 1;
    localparam int L_LFT = 2;
    localparam int L_RGT = 3;
    localparam int L_TL  = 4;
    localparam int L_TR  = 5;
    localparam int L_BL  = 6;
    localparam int L_BR  = 7;

    localparam logic [SHAPE_W-1:0] SHAPE_NONE      = 4'd0;
    localparam logic [SHAPE_W-1:0] SHAPE_TOP_LEFT  = 4'd1;
    localparam logic [SHAPE_W-1:0] SHAPE_TOP_RIGHT = 4'd2;
    localparam logic [SHAPE_W-1:0] SHAPE_BOT_LEFT  = 4'd3;
    localparam logic [SHAPE_W-1:0] SHAPE_BOT_RIGHT = 4'd4;
    localparam logic [SHAPE_W-1:0] SHAPE_DIAG_TL   = 4'd5;
    localparam logic [SHAPE_W-1:0] SHAPE_DIAG_TR   = 4'd6;
    localparam logic [SHAPE_W-1:0] SHAPE_DIAG_BL   = 4'd7;
    localparam logic [SHAPE_W-1:0] SHAPE_DIAG_BR   = 4'd8;
    localparam logic [SHAPE_W-1:0] SHAPE_TOP       = 4'd9;
    localparam logic [SHAPE_W-1:0] SHAPE_BOT       = 4'd10;
    localparam logic [SHAPE_W-1:0] SHAPE_LEFT      = 4'd11;
    localparam logic [SHAPE_W-1:0] SHAPE_RIGHT     = 4'd12;

    typedef struct packed {
        logic                hit;
        logic                none;
        logic [BORDER_W-1:0] value;
    } lane_res_t;

endpackage

[src/terrain_border_selector_top.sv]
// Top level of the terrain border selector.
//
// Input channel s_*: one item per handshake. tuser selects the operation: a
// write item loads one pair table entry (row = center, column = top) and
// gives no result; a classify item gives exactly one result on m_*.
// Result tdata: border index in the low nibble, shape code in the high one.
// Config port: cfg_we with cfg_index 0 writes the loaded mask, 1 the style
// mask; write only while the block is idle.
// A classify result passes the stage 1 (table read), stage 2 and output registers.
// Throughput: one item per cycle unless a full pipe waits on m_tready; the pair
// table is one column RAM per terrain, all read at the center row in parallel,
// so eight lanes and the center lookup see the whole row in the same cycle.
// Reset: a clearing pass writes "no border" into every table row, one row a
// cycle; s_tready stays low until it ends.
// Stall: each stage only moves when the next one is free, so the block keeps
// taking items into empty stages while a result waits on m_tready, and holds
// everything once the pipe is full.
module terrain_border_selector_top
    import tbs_pkg::*;
#(
    parameter int TERRAIN_COUNT = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // center[4:0] top[9:5] bottom[14:10] left[19:15] right[24:20] top_left[29:25]
    // top_right[34:30] bottom_left[39:35] bottom_right[44:40] edge_flags[48:45]
    // entry_value[53:49], zero pad [55:54]
    input  logic [55:0] s_tdata,
    // operation[0]
    input  logic        s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // border_index[3:0] shape_code[7:4]
    output logic [7:0]  m_tdata,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [15:0] cfg_data
);

    localparam int AW = $clog2(TERRAIN_COUNT);

    // config
    logic [MASK_W-1:0] loaded_mask_reg;
    logic [MASK_W-1:0] style1_mask_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            loaded_mask_reg <= '0;
            style1_mask_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (reg_idx_t'(cfg_index))
                REG_LOADED_MASK: loaded_mask_reg <= cfg_data;
                REG_STYLE1_MASK: style1_mask_reg <= cfg_data;
                default:         loaded_mask_reg <= loaded_mask_reg;
            endcase
        end
    end

    // input fields
    logic [TERRAIN_W-1:0] in_center;
    logic [TERRAIN_W-1:0] in_nbr [NUM_LANES];
    logic [3:0]           in_edges;
    logic [TERRAIN_W-1:0] in_entry;
    logic [TERRAIN_W-1:0] nbr_sel [NUM_LANES];
    logic [6:0]           center_ext;
    logic [6:0]           col_ext;

    always_comb
    begin
        in_center = s_tdata[4:0];
        for (int i = 0; i < NUM_LANES; i++)
        begin
            in_nbr[i] = s_tdata[5*(i+1) +: 5];
        end
        in_edges   = s_tdata[48:45];
        in_entry   = s_tdata[53:49];
        center_ext = {2'b00, in_center};
        col_ext    = {2'b00, in_nbr[L_TOP]};

        for (int i = 0; i < NUM_LANES; i++)
        begin
            nbr_sel[i] = in_nbr[i];
        end
        if (in_edges[0])
        begin
            nbr_sel[L_TOP] = in_center;
            nbr_sel[L_TL]  = in_center;
            nbr_sel[L_TR]  = in_center;
        end
        if (in_edges[1])
        begin
            nbr_sel[L_BOT] = in_center;
            nbr_sel[L_BL]  = in_center;
            nbr_sel[L_BR]  = in_center;
        end
        if (in_edges[2])
        begin
            nbr_sel[L_LFT] = in_center;
            nbr_sel[L_TL]  = in_center;
            nbr_sel[L_BL]  = in_center;
        end
        if (in_edges[3])
        begin
            nbr_sel[L_RGT] = in_center;
            nbr_sel[L_TR]  = in_center;
            nbr_sel[L_BR]  = in_center;
        end
    end

    // pipeline flow
    logic s1_valid_reg;
    logic s2_valid_reg;
    logic out_valid_reg;
    logic out_load;
    logic s2_load;
    logic s1_load;
    logic s_acc;
    logic wr_acc;
    logic clear_reg;
    logic [AW-1:0] clr_cnt_reg;
    logic [AW-1:0] clr_cnt_next;

    assign out_load = !out_valid_reg || m_tready;
    assign s2_load  = !s2_valid_reg || out_load;
    assign s1_load  = !s1_valid_reg || s2_load;
    assign s_tready = s1_load && !clear_reg;
    assign s_acc    = s_tvalid && s_tready;
    assign wr_acc   = s_acc && (op_t'(s_tuser) == OP_WRITE)
                      && (center_ext < 7'(TERRAIN_COUNT)) && (col_ext < 7'(TERRAIN_COUNT));

    // clearing pass after reset
    assign clr_cnt_next = clr_cnt_reg + 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_reg   <= 1'b1;
            clr_cnt_reg <= '0;
        end
        else if (clear_reg)
        begin
            clr_cnt_reg <= clr_cnt_next;
            if (clr_cnt_reg == AW'(TERRAIN_COUNT - 1))
            begin
                clear_reg <= 1'b0;
            end
        end
    end

    // pair table: one column RAM per terrain
    logic [TERRAIN_COUNT-1:0][TERRAIN_W-1:0] row;
    logic [AW-1:0]                           ram_waddr;
    logic [TERRAIN_W-1:0]                    ram_wdata;

    assign ram_waddr = clear_reg ? clr_cnt_reg : center_ext[AW-1:0];
    assign ram_wdata = clear_reg ? ENTRY_NONE : in_entry;

    for (genvar j = 0; j < TERRAIN_COUNT; j++)
    begin : g_col
        logic col_we;
        assign col_we = clear_reg || (wr_acc && (col_ext == 7'(j)));

        tbs_ram #(
            .WIDTH (TERRAIN_W),
            .DEPTH (TERRAIN_COUNT)
        ) u_ram (
            .clk   (clk),
            .we    (col_we),
            .waddr (ram_waddr),
            .wdata (ram_wdata),
            .re    (s_acc),
            .raddr (center_ext[AW-1:0]),
            .rdata (row[j])
        );
    end

    // stage 1: table row arrives
    logic [TERRAIN_W-1:0] s1_center_reg;
    logic                 s1_cok_reg;
    logic [TERRAIN_W-1:0] s1_nbr_reg [NUM_LANES];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s1_load)
        begin
            s1_valid_reg <= s_acc && (op_t'(s_tuser) == OP_CLASSIFY);
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_acc)
        begin
            s1_center_reg <= in_center;
            s1_cok_reg    <= center_ext < 7'(TERRAIN_COUNT);
            s1_nbr_reg    <= nbr_sel;
        end
    end

    // lanes
    lane_res_t [NUM_LANES-1:0] lane_res;
    lane_res_t                 center_res;

    for (genvar i = 0; i < NUM_LANES; i++)
    begin : g_lane
        tbs_lane #(
            .TERRAIN_COUNT (TERRAIN_COUNT)
        ) u_lane (
            .row         (row),
            .center      (s1_center_reg),
            .neighbor    (s1_nbr_reg[i]),
            .center_ok   (s1_cok_reg),
            .loaded_mask (loaded_mask_reg),
            .res         (lane_res[i])
        );
    end

    tbs_lane #(
        .TERRAIN_COUNT (TERRAIN_COUNT)
    ) u_center_lane (
        .row         (row),
        .center      (s1_center_reg),
        .neighbor    (s1_center_reg),
        .center_ok   (s1_cok_reg),
        .loaded_mask (loaded_mask_reg),
        .res         (center_res)
    );

    // stage 2: lane results
    lane_res_t [NUM_LANES-1:0] s2_lane_reg;
    lane_res_t                 s2_center_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (s2_load)
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_load)
        begin
            s2_lane_reg   <= lane_res;
            s2_center_reg <= center_res;
        end
    end

    // merge and output register
    logic [BORDER_W-1:0] merge_index;
    logic [SHAPE_W-1:0]  merge_shape;
    logic [BORDER_W-1:0] out_index_reg;
    logic [SHAPE_W-1:0]  out_shape_reg;

    tbs_merge u_merge (
        .lanes        (s2_lane_reg),
        .center_res   (s2_center_reg),
        .style1_mask  (style1_mask_reg),
        .border_index (merge_index),
        .shape_code   (merge_shape)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_index_reg <= merge_index;
            out_shape_reg <= merge_shape;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_shape_reg, out_index_reg};

    // checks
`include "terrain_border_selector_top_assert.svh"

    `TBS_ASSERT_IMP(a_no_accept_in_clear, clear_reg, !s_tready)
    `TBS_ASSERT_NEXT(a_write_gives_no_item, s_acc && (op_t'(s_tuser) == OP_WRITE), !s1_valid_reg)
    `TBS_ASSERT_NEXT(a_s2_only_from_s1, s2_load && !s1_valid_reg, !s2_valid_reg)
    `TBS_ASSERT_NEXT(a_out_only_from_s2, out_load && !s2_valid_reg, !m_tvalid)

endmodule

[src/tbs_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module tbs_ram #(
    parameter int WIDTH = 5,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[src/tbs_lane.sv]
// One neighbor lane: pair entry lookup and counting test.
module tbs_lane
    import tbs_pkg::*;
#(
    parameter int TERRAIN_COUNT = 32
) (
    input  logic [TERRAIN_COUNT-1:0][TERRAIN_W-1:0] row,
    input  logic [TERRAIN_W-1:0]                    center,
    input  logic [TERRAIN_W-1:0]                    neighbor,
    input  logic                                    center_ok,
    input  logic [MASK_W-1:0]                       loaded_mask,
    output lane_res_t                               res
);

    localparam int AW = $clog2(TERRAIN_COUNT);

    logic [6:0]           nbr_ext;
    logic                 col_ok;
    logic [TERRAIN_W-1:0] entry;
    logic                 none;

    always_comb
    begin
        nbr_ext   = {2'b00, neighbor};
        col_ok    = nbr_ext < 7'(TERRAIN_COUNT);
        entry     = row[nbr_ext[AW-1:0]];
        none      = !(center_ok && col_ok) || entry[TERRAIN_W-1];
        res.none  = none;
        res.value = entry[BORDER_W-1:0];
        res.hit   = (neighbor != center) && !none && loaded_mask[entry[BORDER_W-1:0]];
    end

endmodule

[src/tbs_merge.sv]
// Merge stage: first counting lane picks the border, lanes vote the shape.
module tbs_merge
    import tbs_pkg::*;
(
    input  lane_res_t [NUM_LANES-1:0] lanes,
    input  lane_res_t                 center_res,
    input  logic [MASK_W-1:0]         style1_mask,
    output logic [BORDER_W-1:0]       border_index,
    output logic [SHAPE_W-1:0]        shape_code
);

    logic                 found;
    logic [BORDER_W-1:0]  border;
    logic [NUM_LANES-1:0] m;
    lane_res_t            b;
    logic [SHAPE_W-1:0]   shape;
    logic                 matched;

    always_comb
    begin
        found  = 1'b0;
        border = '0;
        for (int i = 0; i < NUM_LANES; i++)
        begin
            if (!found && lanes[i].hit)
            begin
                found  = 1'b1;
                border = lanes[i].value;
            end
        end

        for (int i = 0; i < NUM_LANES; i++)
        begin
            b    = lanes[i].hit ? lanes[i] : center_res;
            m[i] = !b.none && (b.value == border);
        end

        matched = 1'b1;
        shape   = SHAPE_NONE;
        if (style1_mask[border])
        begin
            shape = {m[L_RGT], m[L_LFT], m[L_BOT], m[L_TOP]};
        end
        else if (m[L_TOP] && m[L_LFT]) shape = SHAPE_TOP_LEFT;
        else if (m[L_TOP] && m[L_RGT]) shape = SHAPE_TOP_RIGHT;
        else if (m[L_BOT] && m[L_LFT]) shape = SHAPE_BOT_LEFT;
        else if (m[L_BOT] && m[L_RGT]) shape = SHAPE_BOT_RIGHT;
        else if (m[L_TOP])             shape = SHAPE_TOP;
        else if (m[L_BOT])             shape = SHAPE_BOT;
        else if (m[L_LFT])             shape = SHAPE_LEFT;
        else if (m[L_RGT])             shape = SHAPE_RIGHT;
        else if (m[L_TL])              shape = SHAPE_DIAG_TL;
        else if (m[L_TR])              shape = SHAPE_DIAG_TR;
        else if (m[L_BL])              shape = SHAPE_DIAG_BL;
        else if (m[L_BR])              shape = SHAPE_DIAG_BR;
        else                           matched = 1'b0;

        if (found && matched)
        begin
            border_index = border;
            shape_code   = shape;
        end
        else
        begin
            border_index = '0;
            shape_code   = SHAPE_NONE;
        end
    end

endmodule

[sim/tb_terrain_border_selector_top.sv]
// Self-checking testbench of the terrain border selector: directed rows, then random phases.
module tb_terrain_border_selector_top
    import tbs_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int HOLD_CYCLES  = 300;
    localparam int PHASES       = 6;
    localparam int PHASE_ITEMS  = 65;
    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        logic [4:0]      entry;
        logic [3:0]      edges;
        logic [7:0][4:0] nb;      // top, bottom, left, right, tl, tr, bl, br
        logic [4:0]      center;
    } tile_item_t;

    typedef struct packed {
        logic [3:0] shape;
        logic [3:0] idx;
    } border_res_t;

    typedef struct packed {
        op_t        op;
        tile_item_t item;
        logic       want_zero;
    } stim_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [55:0] s_tdata = '0;
    logic        s_tuser = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;
    logic        cfg_we = 1'b0;
    logic        cfg_index = 1'b0;
    logic [15:0] cfg_data = '0;

    logic [4:0]  pair_table [32][32];
    logic [15:0] loaded_mask = '0;
    logic [15:0] style1_mask = '0;

    border_res_t border_due [$];
    int          fail_count = 0;
    int          n_checked = 0;
    int          n_tiles = 0;
    int          n_writes = 0;
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    bit          hold_go = 1'b0;
    logic        holding = 1'b0;

    terrain_border_selector_top dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    initial
    begin
        forever
        begin
            #6 clk = ~clk;
        end
    end

    initial
    begin
        #2_000_000;
        $display("== FAIL ==");
        $display("timeout");
        $finish;
    end

    initial
    begin
        for (int r = 0; r < 32; r++)
            for (int c = 0; c < 32; c++)
                pair_table[r][c] = ENTRY_NONE;
    end

    function automatic logic border_live(input logic [4:0] e);
        return !e[4] && loaded_mask[e[3:0]];
    endfunction

    function automatic border_res_t pick_border(input tile_item_t t);
        logic [4:0]      c;
        logic [7:0][4:0] nbr;
        logic [4:0]      ent;
        logic [3:0]      bnum;
        logic [7:0]      hit;
        logic            found;
        border_res_t     res;
        c     = t.center;
        nbr   = t.nb;
        res   = '0;
        found = 1'b0;
        ent   = ENTRY_NONE;
        if (t.edges[0])
        begin
            nbr[L_TOP] = c; nbr[L_TL] = c; nbr[L_TR] = c;
        end
        if (t.edges[1])
        begin
            nbr[L_BOT] = c; nbr[L_BL] = c; nbr[L_BR] = c;
        end
        if (t.edges[2])
        begin
            nbr[L_LFT] = c; nbr[L_TL] = c; nbr[L_BL] = c;
        end
        if (t.edges[3])
        begin
            nbr[L_RGT] = c; nbr[L_TR] = c; nbr[L_BR] = c;
        end
        for (int i = 0; i < NUM_LANES; i++)
            if (nbr[i] != c && !border_live(pair_table[c][nbr[i]]))
                nbr[i] = c;
        for (int i = 0; i < NUM_LANES; i++)
            if (!found && nbr[i] != c)
            begin
                found = 1'b1;
                ent   = pair_table[c][nbr[i]];
            end
        if (!found || !border_live(ent))
            return res;
        bnum = ent[3:0];
        for (int i = 0; i < NUM_LANES; i++)
            hit[i] = (pair_table[c][nbr[i]] == {1'b0, bnum});
        res.idx = bnum;
        if (style1_mask[bnum])
            res.shape = {hit[L_RGT], hit[L_LFT], hit[L_BOT], hit[L_TOP]};
        else if (hit[L_TOP] && hit[L_LFT]) res.shape = SHAPE_TOP_LEFT;
        else if (hit[L_TOP] && hit[L_RGT]) res.shape = SHAPE_TOP_RIGHT;
        else if (hit[L_BOT] && hit[L_LFT]) res.shape = SHAPE_BOT_LEFT;
        else if (hit[L_BOT] && hit[L_RGT]) res.shape = SHAPE_BOT_RIGHT;
        else if (hit[L_TOP]) res.shape = SHAPE_TOP;
        else if (hit[L_BOT]) res.shape = SHAPE_BOT;
        else if (hit[L_LFT]) res.shape = SHAPE_LEFT;
        else if (hit[L_RGT]) res.shape = SHAPE_RIGHT;
        else if (hit[L_TL])  res.shape = SHAPE_DIAG_TL;
        else if (hit[L_TR])  res.shape = SHAPE_DIAG_TR;
        else if (hit[L_BL])  res.shape = SHAPE_DIAG_BL;
        else if (hit[L_BR])  res.shape = SHAPE_DIAG_BR;
        else
            res = '0;
        return res;
    endfunction

    function automatic stim_row_t mk_write(input logic [4:0] row, input logic [4:0] col,
                                           input logic [4:0] entry);
        stim_row_t s;
        s               = '0;
        s.op            = OP_WRITE;
        s.item.center   = row;
        s.item.nb[L_TOP] = col;
        s.item.entry    = entry;
        return s;
    endfunction

    function automatic stim_row_t mk_tile(input logic [4:0] c, input logic [4:0] t,
                                          input logic [4:0] b, input logic [4:0] l,
                                          input logic [4:0] r, input logic [4:0] tl,
                                          input logic [4:0] tr, input logic [4:0] bl,
                                          input logic [4:0] br, input logic [3:0] edges,
                                          input logic want_zero);
        stim_row_t s;
        s             = '0;
        s.op          = OP_CLASSIFY;
        s.item.center = c;
        s.item.nb     = {br, bl, tr, tl, r, l, b, t};
        s.item.edges  = edges;
        s.want_zero   = want_zero;
        return s;
    endfunction

    function automatic logic [4:0] pick_terrain(input logic [3:0][4:0] pool);
        if ($urandom_range(99) < 80)
            return pool[2'($urandom_range(3))];
        return 5'($urandom_range(31));
    endfunction

    task automatic make_random(input logic [3:0][4:0] pool, output stim_row_t s);
        s.want_zero = 1'b0;
        s.item      = tile_item_t'(54'({$urandom, $urandom}));
        if ($urandom_range(99) < 25)
        begin
            s.op             = OP_WRITE;
            s.item.center    = pick_terrain(pool);
            s.item.nb[L_TOP] = pick_terrain(pool);
            case ($urandom_range(6))
                0:       s.item.entry = ENTRY_NONE;
                1:       s.item.entry = 5'($urandom_range(31));
                default: s.item.entry = 5'($urandom_range(15));
            endcase
        end
        else
        begin
            s.op          = OP_CLASSIFY;
            s.item.center = pick_terrain(pool);
            for (int i = 0; i < NUM_LANES; i++)
                s.item.nb[i] = $urandom_range(1) ? s.item.center : pick_terrain(pool);
            if ($urandom_range(1))
                s.item.edges = '0;
        end
    endtask

    task automatic push_item(input stim_row_t s);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= s.op;
        s_tdata  <= {2'b00, s.item};
        do
            @(posedge clk);
        while (!s_tready);
        if (s.op == OP_WRITE)
        begin
            pair_table[s.item.center][s.item.nb[L_TOP]] = s.item.entry;
            n_writes++;
        end
        else
        begin
            border_due.push_back(s.want_zero ? border_res_t'('0) : pick_border(s.item));
            n_tiles++;
        end
    endtask

    task automatic write_masks(input logic [15:0] loaded, input logic [15:0] style1);
        cfg_we    <= 1'b1;
        cfg_index <= REG_LOADED_MASK;
        cfg_data  <= loaded;
        @(posedge clk);
        cfg_index <= REG_STYLE1_MASK;
        cfg_data  <= style1;
        @(posedge clk);
        cfg_we      <= 1'b0;
        loaded_mask = loaded;
        style1_mask = style1;
    endtask

    task automatic settle();
        while (border_due.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic check_result(input logic [7:0] data);
        border_res_t want;
        if (border_due.size() == 0)
        begin
            fail_count++;
            if (fail_count <= REPORT_LIMIT)
                $display("unexpected result tdata=%h", data);
        end
        else
        begin
            want = border_due.pop_front();
            n_checked++;
            if (data[3:0] !== want.idx || data[7:4] !== want.shape)
            begin
                fail_count++;
                if (fail_count <= REPORT_LIMIT)
                    $display("mismatch: index exp %0d got %0d, shape exp %0d got %0d",
                             want.idx, data[3:0], want.shape, data[7:4]);
            end
        end
    endtask

    initial
    begin
        forever
        begin
            @(posedge clk);
            if (rst_n && m_tvalid && m_tready)
                check_result(m_tdata);
            m_tready <= !holding && ($urandom_range(99) >= recv_stall_pct);
        end
    end

    initial
    begin
        wait (hold_go);
        holding <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        holding <= 1'b0;
    end

    initial
    begin
        stim_row_t        dir_rows [$];
        stim_row_t        s;
        logic [3:0][4:0]  pool;
        logic [15:0]      lm;
        logic [15:0]      sm;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        write_masks(16'h7FFF, 16'h00FF);

        // empty table, then single edges, corners, diagonals, edge flags
        dir_rows.push_back(mk_tile(0, 1, 1, 1, 1, 1, 1, 1, 1, 4'h0, 1'b1));
        dir_rows.push_back(mk_write(0, 1, 9));
        dir_rows.push_back(mk_tile(0, 1, 0, 0, 0, 0, 0, 0, 0, 4'h0, 1'b0));
        dir_rows.push_back(mk_tile(0, 1, 1, 1, 1, 1, 1, 1, 1, 4'h0, 1'b0));
        dir_rows.push_back(mk_tile(0, 1, 1, 1, 1, 1, 1, 1, 1, 4'hF, 1'b1));
        dir_rows.push_back(mk_tile(0, 0, 1, 0, 1, 0, 0, 0, 0, 4'h0, 1'b0));
        dir_rows.push_back(mk_tile(0, 0, 0, 1, 0, 0, 0, 0, 0, 4'h0, 1'b0));
        dir_rows.push_back(mk_tile(0, 0, 0, 0, 1, 0, 0, 0, 0, 4'h0, 1'b0));
        dir_rows.push_back(mk_tile(0, 0, 1, 0, 0, 0, 0, 0, 0, 4'h0, 1'b0));
        dir_rows.push_back(mk_tile(0, 0, 0, 0, 0, 1, 0, 0, 0, 4'h0, 1'b0));
        dir_rows.push_back(mk_tile(0, 0, 0, 0, 0, 0, 1, 0, 0, 4'h0, 1'b0));
        dir_rows.push_back(mk_tile(0, 0, 0, 0, 0, 0, 0, 1, 0, 4'h0, 1'b0));
        dir_rows.push_back(mk_tile(0, 0, 0, 0, 0, 0, 0, 0, 1, 4'h0, 1'b0));
        dir_rows.push_back(mk_tile(0, 1, 1, 1, 1, 1, 1, 1, 1, 4'h1, 1'b0));
        dir_rows.push_back(mk_tile(0, 1, 1, 1, 1, 1, 1, 1, 1, 4'h5, 1'b0));
        // edge-mask style border
        dir_rows.push_back(mk_write(0, 2, 3));
        dir_rows.push_back(mk_tile(0, 2, 2, 1, 2, 0, 0, 0, 0, 4'h0, 1'b0));
        // border not loaded
        dir_rows.push_back(mk_write(31, 30, 15));
        dir_rows.push_back(mk_tile(31, 30, 30, 30, 30, 30, 30, 30, 30, 4'h0, 1'b1));
        // edge-mask border matched on diagonals only
        dir_rows.push_back(mk_write(31, 0, 0));
        dir_rows.push_back(mk_tile(31, 31, 31, 31, 31, 0, 0, 0, 0, 4'h0, 1'b0));
        // negative entry other than no-border
        dir_rows.push_back(mk_write(5, 6, 5'h10));
        dir_rows.push_back(mk_tile(5, 6, 6, 6, 6, 6, 6, 6, 6, 4'h0, 1'b1));
        // center-center entry seen by replaced neighbors
        dir_rows.push_back(mk_write(0, 0, 9));
        dir_rows.push_back(mk_tile(0, 1, 0, 0, 0, 0, 0, 0, 0, 4'h0, 1'b0));
        dir_rows.push_back(mk_write(0, 1, ENTRY_NONE));
        dir_rows.push_back(mk_tile(0, 1, 1, 1, 1, 1, 1, 1, 1, 4'h0, 1'b0));

        foreach (dir_rows[k])
            push_item(dir_rows[k]);
        s_tvalid <= 1'b0;
        settle();

        for (int ph = 0; ph < PHASES; ph++)
        begin
            case (ph)
                0:       begin lm = 16'hFFFF; sm = 16'h0000; end
                1:       begin lm = 16'hFFFF; sm = 16'hFFFF; end
                3:       begin lm = 16'h0000; sm = 16'hFFFF; end
                default: begin lm = 16'($urandom); sm = 16'($urandom); end
            endcase
            write_masks(lm, sm);
            case (ph % 4)
                0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1:       begin send_idle_pct = 60; recv_stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  recv_stall_pct = 60; end
                default: begin send_idle_pct = 22; recv_stall_pct = 22; end
            endcase
            for (int i = 0; i < 4; i++)
                pool[i] = 5'($urandom_range(31));
            if (ph == 4)
                hold_go = 1'b1;
            repeat (PHASE_ITEMS)
            begin
                make_random(pool, s);
                push_item(s);
            end
            s_tvalid <= 1'b0;
            settle();
        end

        $display("covered %0d tile lookups and %0d table writes, %0d results checked",
                 n_tiles, n_writes, n_checked);
        $display("over %0d mask settings with idle, stall and hold-off mixes", PHASES + 1);
        if (fail_count == 0 && border_due.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

[terrain_border_selector_top.f]
+incdir+src
src/tbs_pkg.sv
src/tbs_ram.sv
src/tbs_lane.sv
src/tbs_merge.sv
src/terrain_border_selector_top.sv
sim/tb_terrain_border_selector_top.sv
